// ===== design/qslerp_pkg.sv =====
// Shared constants, types and the arctangent table of the quaternion slerp core.
// No dependencies; every other design file refers to it by scoped names.
package qslerp_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CORDIC_STEPS = 16;

  localparam int COMP_W = 16;
  localparam int NEG_W = COMP_W + 1;
  localparam int BLEND_W = 16;
  localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(32768);

  localparam int Q = 30;
  localparam int UNIT_W = Q + 1;
  localparam int DOT_W = 2 * COMP_W + 2;
  localparam int DOT_SHIFT = 2 * FRAC_BITS - Q;
  localparam int SHR = (DOT_SHIFT > 0) ? DOT_SHIFT : 0;
  localparam int SHL = (DOT_SHIFT < 0) ? -DOT_SHIFT : 0;
  localparam int SQRT_W = 2 * Q + 2;
  localparam int ANG_W = Q + 4;
  localparam int DEN_W = Q + 2;
  localparam int NUM_W = 2 * Q + 4;
  localparam int W_W = Q + 3;
  localparam int TMUL_W = DEN_W + BLEND_W;
  localparam int PROD_W = NEG_W + W_W;
  localparam int SUM_W = PROD_W + 1;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [W_W-1:0] wgt_t;

  typedef struct packed {
    logic [3:0][NEG_W-1:0] a;
    logic [3:0][COMP_W-1:0] b;
    logic [BLEND_W-1:0] blend;
  } pair_t;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage

// ===== design/qslerp_in_if.sv =====
// Request channel of the slerp core: two quaternions and a blend factor.
// Depends on qslerp_pkg for field widths.
interface qslerp_in_if;
  logic valid;
  logic ready;
  logic signed [qslerp_pkg::COMP_W-1:0] a_w, a_x, a_y, a_z;
  logic signed [qslerp_pkg::COMP_W-1:0] b_w, b_x, b_y, b_z;
  logic [qslerp_pkg::BLEND_W-1:0] blend;

  modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend,
                  input ready);
  modport sink (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend,
                output ready);
endinterface

// ===== design/qslerp_out_if.sv =====
// Result channel of the slerp core: blended quaternion and degenerate flag.
// Depends on qslerp_pkg for field widths.
interface qslerp_out_if;
  logic valid;
  logic ready;
  logic signed [qslerp_pkg::COMP_W-1:0] r_w, r_x, r_y, r_z;
  logic degenerate;

  modport source (output valid, r_w, r_x, r_y, r_z, degenerate, input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, degenerate, output ready);
endinterface

// ===== design/quaternion_slerp_core.sv =====
// Quaternion slerp core: takes a request of two Q1.14 quaternions and a Q1.15 blend
// factor and returns one blended, saturated quaternion with a degenerate flag.
// The block is fully pipelined and accepts one request every cycle while it is not
// held; each request passes through the one-bit-per-stage square root (31 stages),
// the vectoring and three-lane rotation CORDIC pipelines (16 stages each) and the
// one-bit-per-stage weight divider (31 stages) on its way to the result. The whole
// pipeline holds when the result register is full and not taken, so ready is low
// exactly in that case.
// Depends on qslerp_pkg, qslerp_in_if, qslerp_out_if and the qslerp_* stages.
module quaternion_slerp_core (
  input logic clk,
  input logic rst,
  qslerp_in_if.sink pair,
  qslerp_out_if.source result
);
  logic adv;
  qslerp_pkg::pair_t in_pair;

  logic f_valid, v_valid, s_valid, d_valid;
  qslerp_pkg::pair_t f_pair, v_pair, s_pair, d_pair;
  logic [qslerp_pkg::UNIT_W-1:0] f_d, f_s0;
  logic v_tp, s_tp, d_dg;
  qslerp_pkg::ang_t v_th, v_rest, v_part;
  qslerp_pkg::ang_t s_th, s_rest, s_part;
  qslerp_pkg::wgt_t d_w0, d_w1;
  logic signed [qslerp_pkg::COMP_W-1:0] r [4];

  assign adv = !result.valid || result.ready;
  assign pair.ready = adv;

  assign in_pair.a[0] = qslerp_pkg::NEG_W'(pair.a_w);
  assign in_pair.a[1] = qslerp_pkg::NEG_W'(pair.a_x);
  assign in_pair.a[2] = qslerp_pkg::NEG_W'(pair.a_y);
  assign in_pair.a[3] = qslerp_pkg::NEG_W'(pair.a_z);
  assign in_pair.b[0] = pair.b_w;
  assign in_pair.b[1] = pair.b_x;
  assign in_pair.b[2] = pair.b_y;
  assign in_pair.b[3] = pair.b_z;
  assign in_pair.blend = pair.blend;

  qslerp_front u_front (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(pair.valid), .in_pair(in_pair),
    .out_valid(f_valid), .out_pair(f_pair), .d(f_d), .s0(f_s0)
  );

  qslerp_vec u_vec (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(f_valid), .in_pair(f_pair), .d(f_d), .s0(f_s0),
    .out_valid(v_valid), .out_pair(v_pair), .theta_pos(v_tp),
    .ang_theta(v_th), .ang_rest(v_rest), .ang_part(v_part)
  );

  qslerp_sin u_sin (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(v_valid), .in_pair(v_pair), .in_theta_pos(v_tp),
    .ang_theta(v_th), .ang_rest(v_rest), .ang_part(v_part),
    .out_valid(s_valid), .out_pair(s_pair), .theta_pos(s_tp),
    .sin_theta(s_th), .sin_rest(s_rest), .sin_part(s_part)
  );

  qslerp_div u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(s_valid), .in_pair(s_pair), .in_theta_pos(s_tp),
    .sin_theta(s_th), .sin_rest(s_rest), .sin_part(s_part),
    .out_valid(d_valid), .out_pair(d_pair), .degenerate(d_dg),
    .w0(d_w0), .w1(d_w1)
  );

  qslerp_mix u_mix (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(d_valid), .in_pair(d_pair), .in_degenerate(d_dg),
    .w0(d_w0), .w1(d_w1),
    .out_valid(result.valid), .r(r), .degenerate(result.degenerate)
  );

  assign result.r_w = r[0];
  assign result.r_x = r[1];
  assign result.r_y = r[2];
  assign result.r_z = r[3];
endmodule

// ===== design/qslerp_front.sv =====
// Front pipeline: dot product, sign fold, Q30 rescale and a one-bit-per-stage
// integer square root of 1 - dot^2. Depends on qslerp_pkg.
module qslerp_front (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  qslerp_pkg::pair_t in_pair,
  output logic out_valid,
  output qslerp_pkg::pair_t out_pair,
  output logic [qslerp_pkg::UNIT_W-1:0] d,
  output logic [qslerp_pkg::UNIT_W-1:0] s0
);
  localparam int UW = qslerp_pkg::UNIT_W;
  localparam int SW = qslerp_pkg::SQRT_W;

  logic v1, v2, v3;
  qslerp_pkg::pair_t p1, p2, p3;
  logic signed [2*qslerp_pkg::COMP_W-1:0] prod1 [4];
  logic [UW-1:0] d2, d3;
  logic [2*UW-1:0] dsq3;

  logic signed [qslerp_pkg::DOT_W-1:0] dot;
  logic [qslerp_pkg::DOT_W-1:0] mag;
  logic [63:0] scaled;
  logic [UW-1:0] d_next;
  qslerp_pkg::pair_t p2_next;

  logic sv [0:UW];
  qslerp_pkg::pair_t sp [0:UW];
  logic [UW-1:0] sd [0:UW];
  logic [SW-1:0] rem [0:UW];
  logic [UW-1:0] root [0:UW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      sv[0] <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      sv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1.a <= in_pair.a;
      p1.b <= in_pair.b;
      p1.blend <= (in_pair.blend > qslerp_pkg::BLEND_ONE) ? qslerp_pkg::BLEND_ONE
                                                           : in_pair.blend;
      for (int k = 0; k < 4; k++) begin
        prod1[k] <= $signed(in_pair.a[k][qslerp_pkg::COMP_W-1:0]) * $signed(in_pair.b[k]);
      end
    end
  end

  always_comb begin
    dot = qslerp_pkg::DOT_W'(prod1[0]) + qslerp_pkg::DOT_W'(prod1[1])
        + qslerp_pkg::DOT_W'(prod1[2]) + qslerp_pkg::DOT_W'(prod1[3]);
    mag = (dot < 0) ? qslerp_pkg::DOT_W'(-dot) : qslerp_pkg::DOT_W'(dot);
    scaled = (64'(mag) << qslerp_pkg::SHL) >> qslerp_pkg::SHR;
    d_next = (scaled > (64'(1) << qslerp_pkg::Q)) ? (UW'(1) << qslerp_pkg::Q)
                                                  : scaled[UW-1:0];
    p2_next = p1;
    for (int k = 0; k < 4; k++) begin
      if (dot < 0) begin
        p2_next.a[k] = qslerp_pkg::NEG_W'(-$signed(p1.a[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2 <= p2_next;
      d2 <= d_next;
      p3 <= p2;
      d3 <= d2;
      dsq3 <= d2 * d2;
      sp[0] <= p3;
      sd[0] <= d3;
      rem[0] <= (SW'(1) << (2 * qslerp_pkg::Q)) - SW'(dsq3);
      root[0] <= '0;
    end
  end

  for (genvar j = 0; j < UW; j++) begin : g_sqrt
    localparam int K = UW - 1 - j;
    logic [SW-1:0] trial;
    logic ge;
    assign trial = (SW'(root[j]) << (K + 1)) + (SW'(1) << (2 * K));
    assign ge = rem[j] >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (adv) begin
        sv[j+1] <= sv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sp[j+1] <= sp[j];
        sd[j+1] <= sd[j];
        rem[j+1] <= ge ? (rem[j] - trial) : rem[j];
        root[j+1] <= ge ? (root[j] | (UW'(1) << K)) : root[j];
      end
    end
  end

  assign out_valid = sv[UW];
  assign out_pair = sp[UW];
  assign d = sd[UW];
  assign s0 = root[UW];
endmodule

// ===== design/qslerp_vec.sv =====
// Vectoring CORDIC pipeline giving theta = acos(|dot|), then the split of theta
// into t*theta and (1-t)*theta. Depends on qslerp_pkg.
module qslerp_vec (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  qslerp_pkg::pair_t in_pair,
  input  logic [qslerp_pkg::UNIT_W-1:0] d,
  input  logic [qslerp_pkg::UNIT_W-1:0] s0,
  output logic out_valid,
  output qslerp_pkg::pair_t out_pair,
  output logic theta_pos,
  output qslerp_pkg::ang_t ang_theta,
  output qslerp_pkg::ang_t ang_rest,
  output qslerp_pkg::ang_t ang_part
);
  localparam int N = qslerp_pkg::CORDIC_STEPS;

  logic cv [0:N];
  qslerp_pkg::pair_t cp [0:N];
  logic zf [0:N];
  qslerp_pkg::ang_t x [0:N];
  qslerp_pkg::ang_t y [0:N];
  qslerp_pkg::ang_t z [0:N];

  logic v1;
  qslerp_pkg::pair_t p1;
  qslerp_pkg::ang_t th1, th_next;
  logic [qslerp_pkg::TMUL_W-1:0] tmul1;
  qslerp_pkg::ang_t tt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cp[0] <= in_pair;
      zf[0] <= (s0 == '0);
      x[0] <= qslerp_pkg::ANG_W'(d);
      y[0] <= qslerp_pkg::ANG_W'(s0);
      z[0] <= '0;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    qslerp_pkg::ang_t dx, dy, da;
    assign dx = y[j] >>> j;
    assign dy = x[j] >>> j;
    assign da = qslerp_pkg::ANG_W'(qslerp_pkg::ATAN_Q30[j % 32]);
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[j+1] <= 1'b0;
      end else if (adv) begin
        cv[j+1] <= cv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cp[j+1] <= cp[j];
        zf[j+1] <= zf[j];
        if (y[j] >= 0) begin
          x[j+1] <= x[j] + dx;
          y[j+1] <= y[j] - dy;
          z[j+1] <= z[j] + da;
        end else begin
          x[j+1] <= x[j] - dx;
          y[j+1] <= y[j] + dy;
          z[j+1] <= z[j] - da;
        end
      end
    end
  end

  assign th_next = zf[N] ? '0 : z[N];
  assign tt = qslerp_pkg::ANG_W'(tmul1 >> (qslerp_pkg::BLEND_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= cv[N];
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= cp[N];
      th1 <= th_next;
      tmul1 <= qslerp_pkg::TMUL_W'(th_next[qslerp_pkg::DEN_W-1:0])
             * qslerp_pkg::TMUL_W'(cp[N].blend);
      out_pair <= p1;
      theta_pos <= th1 > 0;
      ang_theta <= th1;
      ang_rest <= th1 - tt;
      ang_part <= tt;
    end
  end
endmodule

// ===== design/qslerp_sin.sv =====
// Three-lane rotation CORDIC pipeline giving gain-scaled sines of theta,
// (1-t)*theta and t*theta. Depends on qslerp_pkg.
module qslerp_sin (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  qslerp_pkg::pair_t in_pair,
  input  logic in_theta_pos,
  input  qslerp_pkg::ang_t ang_theta,
  input  qslerp_pkg::ang_t ang_rest,
  input  qslerp_pkg::ang_t ang_part,
  output logic out_valid,
  output qslerp_pkg::pair_t out_pair,
  output logic theta_pos,
  output qslerp_pkg::ang_t sin_theta,
  output qslerp_pkg::ang_t sin_rest,
  output qslerp_pkg::ang_t sin_part
);
  localparam int N = qslerp_pkg::CORDIC_STEPS;

  logic cv [0:N];
  qslerp_pkg::pair_t cp [0:N];
  logic tp [0:N];
  qslerp_pkg::ang_t x [0:N][3];
  qslerp_pkg::ang_t y [0:N][3];
  qslerp_pkg::ang_t z [0:N][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cp[0] <= in_pair;
      tp[0] <= in_theta_pos;
      for (int l = 0; l < 3; l++) begin
        x[0][l] <= qslerp_pkg::ANG_W'(1) <<< qslerp_pkg::Q;
        y[0][l] <= '0;
      end
      z[0][0] <= ang_theta;
      z[0][1] <= ang_rest;
      z[0][2] <= ang_part;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    qslerp_pkg::ang_t da;
    assign da = qslerp_pkg::ANG_W'(qslerp_pkg::ATAN_Q30[j % 32]);
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[j+1] <= 1'b0;
      end else if (adv) begin
        cv[j+1] <= cv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cp[j+1] <= cp[j];
        tp[j+1] <= tp[j];
        for (int l = 0; l < 3; l++) begin
          if (z[j][l] >= 0) begin
            x[j+1][l] <= x[j][l] - (y[j][l] >>> j);
            y[j+1][l] <= y[j][l] + (x[j][l] >>> j);
            z[j+1][l] <= z[j][l] - da;
          end else begin
            x[j+1][l] <= x[j][l] + (y[j][l] >>> j);
            y[j+1][l] <= y[j][l] - (x[j][l] >>> j);
            z[j+1][l] <= z[j][l] + da;
          end
        end
      end
    end
  end

  assign out_valid = cv[N];
  assign out_pair = cp[N];
  assign theta_pos = tp[N];
  assign sin_theta = y[N][0];
  assign sin_rest = y[N][1];
  assign sin_part = y[N][2];
endmodule

// ===== design/qslerp_div.sv =====
// Two-lane restoring divider pipeline, one quotient bit per stage, forming the
// saturated Q30 weights sin(rest)/sin(theta) and sin(part)/sin(theta). Depends on qslerp_pkg.
module qslerp_div (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  qslerp_pkg::pair_t in_pair,
  input  logic in_theta_pos,
  input  qslerp_pkg::ang_t sin_theta,
  input  qslerp_pkg::ang_t sin_rest,
  input  qslerp_pkg::ang_t sin_part,
  output logic out_valid,
  output qslerp_pkg::pair_t out_pair,
  output logic degenerate,
  output qslerp_pkg::wgt_t w0,
  output qslerp_pkg::wgt_t w1
);
  localparam int QB = qslerp_pkg::Q + 1;
  localparam int NW = qslerp_pkg::NUM_W;

  logic v0;
  qslerp_pkg::pair_t p0;
  logic dg0;
  logic [qslerp_pkg::DEN_W-1:0] den0;
  logic [1:0] neg0;
  logic [NW-1:0] num0 [2];

  logic cv [0:QB];
  qslerp_pkg::pair_t cp [0:QB];
  logic dg [0:QB];
  logic [qslerp_pkg::DEN_W-1:0] den [0:QB];
  logic [1:0] neg [0:QB];
  logic [1:0] over [0:QB];
  logic [NW-1:0] rem [0:QB][2];
  logic [QB-1:0] quo [0:QB][2];

  qslerp_pkg::ang_t num_in [2];
  qslerp_pkg::wgt_t mag_w [2];

  assign num_in[0] = sin_rest;
  assign num_in[1] = sin_part;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      cv[0] <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      cv[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= in_pair;
      dg0 <= !in_theta_pos || (sin_theta <= 0);
      den0 <= sin_theta[qslerp_pkg::DEN_W-1:0];
      for (int l = 0; l < 2; l++) begin
        neg0[l] <= num_in[l] < 0;
        num0[l] <= (num_in[l] < 0) ? (NW'(-num_in[l]) << qslerp_pkg::Q)
                                   : (NW'(num_in[l]) << qslerp_pkg::Q);
      end
      cp[0] <= p0;
      dg[0] <= dg0;
      den[0] <= den0;
      neg[0] <= neg0;
      for (int l = 0; l < 2; l++) begin
        over[0][l] <= num0[l] >= (NW'(den0) << QB);
        rem[0][l] <= num0[l];
        quo[0][l] <= '0;
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [NW-1:0] trial;
    assign trial = NW'(den[j]) << K;
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[j+1] <= 1'b0;
      end else if (adv) begin
        cv[j+1] <= cv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cp[j+1] <= cp[j];
        dg[j+1] <= dg[j];
        den[j+1] <= den[j];
        neg[j+1] <= neg[j];
        over[j+1] <= over[j];
        for (int l = 0; l < 2; l++) begin
          if (rem[j][l] >= trial) begin
            rem[j+1][l] <= rem[j][l] - trial;
            quo[j+1][l] <= quo[j][l] | (QB'(1) << K);
          end else begin
            rem[j+1][l] <= rem[j][l];
            quo[j+1][l] <= quo[j][l];
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag_w[l] = over[QB][l] ? (qslerp_pkg::W_W'(1) <<< QB)
                             : qslerp_pkg::W_W'(quo[QB][l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pair <= cp[QB];
      degenerate <= dg[QB];
      w0 <= neg[QB][0] ? -mag_w[0] : mag_w[0];
      w1 <= neg[QB][1] ? -mag_w[1] : mag_w[1];
    end
  end
endmodule

// ===== design/qslerp_mix.sv =====
// Output pipeline: weighted sum of the two quaternions, rounding, saturation
// and the result register. Depends on qslerp_pkg.
module qslerp_mix (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  qslerp_pkg::pair_t in_pair,
  input  logic in_degenerate,
  input  qslerp_pkg::wgt_t w0,
  input  qslerp_pkg::wgt_t w1,
  output logic out_valid,
  output logic signed [qslerp_pkg::COMP_W-1:0] r [4],
  output logic degenerate
);
  localparam int CW = qslerp_pkg::COMP_W;

  logic v1, dg1;
  logic signed [qslerp_pkg::PROD_W-1:0] pa [4];
  logic signed [qslerp_pkg::PROD_W-1:0] pb [4];
  logic signed [qslerp_pkg::SUM_W-1:0] sum [4];
  logic signed [qslerp_pkg::SUM_W-1:0] rs [4];
  logic signed [CW-1:0] sat [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dg1 <= in_degenerate;
      for (int k = 0; k < 4; k++) begin
        pa[k] <= $signed(in_pair.a[k]) * w0;
        pb[k] <= $signed(in_pair.b[k]) * w1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = qslerp_pkg::SUM_W'(pa[k]) + qslerp_pkg::SUM_W'(pb[k])
             + (qslerp_pkg::SUM_W'(1) <<< (qslerp_pkg::Q - 1));
      rs[k] = sum[k] >>> qslerp_pkg::Q;
      if (rs[k] > qslerp_pkg::SUM_W'(32767)) begin
        sat[k] = CW'(32767);
      end else if (rs[k] < -qslerp_pkg::SUM_W'(32768)) begin
        sat[k] = CW'(-32768);
      end else begin
        sat[k] = rs[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      degenerate <= dg1;
      for (int k = 0; k < 4; k++) begin
        r[k] <= dg1 ? '0 : sat[k];
      end
    end
  end
endmodule
